// ===== design/rhsv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSV package
// Shared types, constants and the restoring divide step for the pipeline.
// ----------------------------------------------------------------------------
package rhsv_pkg;

	localparam int CHAN_W     = 8;
	localparam int FIELD_W    = 15;
	localparam int NUM_W      = 23;
	localparam int QUO_W      = 15;
	localparam int DIV_STEPS  = 3;
	localparam int DIV_STAGES = QUO_W / DIV_STEPS;

	localparam logic [FIELD_W-1:0] HUE_FULL      = 15'd23040;
	localparam logic [FIELD_W-1:0] HUE_GREEN_OFS = 15'd7680;
	localparam logic [FIELD_W-1:0] HUE_BLUE_OFS  = 15'd15360;
	localparam logic [FIELD_W-1:0] HUE_LIMIT     = 15'd23039;
	localparam logic [FIELD_W-1:0] PCT_LIMIT     = 15'd25600;

	localparam logic [11:0] HUE_UNIT  = 12'd3840;
	localparam logic [14:0] PCT_SCALE = 15'd25600;

	// value = floor(25600 * max / 255) as one multiply by a scaled reciprocal
	localparam int          VAL_SHIFT = 31;
	localparam longint      CHAN_FULL = 255;
	localparam longint      VAL_RECIP = ((64'd1 << VAL_SHIFT) + CHAN_FULL - 1) / CHAN_FULL;
	localparam int          VAL_MUL_W = 38;
	localparam logic [VAL_MUL_W-1:0] VAL_MUL = VAL_MUL_W'(longint'(PCT_SCALE) * VAL_RECIP);
	localparam int          VAL_PROD_W = VAL_MUL_W + CHAN_W;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [FIELD_W-1:0] hue;
		logic [FIELD_W-1:0] saturation;
		logic [FIELD_W-1:0] value;
	} hsv_t;

	typedef enum logic [1:0] {
		HUE_GRAY  = 2'd0,
		HUE_RED   = 2'd1,
		HUE_GREEN = 2'd2,
		HUE_BLUE  = 2'd3
	} hue_sel_t;

	typedef struct packed {
		logic [CHAN_W-1:0] rem;
		logic [QUO_W-1:0]  acc;
		logic [CHAN_W-1:0] den;
	} div_lane_t;

	typedef struct packed {
		hue_sel_t           sel;
		logic               neg;
		logic               black;
		logic [FIELD_W-1:0] value;
	} side_t;

	typedef struct packed {
		div_lane_t hue;
		div_lane_t sat;
		side_t     side;
	} div_item_t;

	// one restoring step: shift in the next numerator bit, subtract if it fits
	function automatic div_lane_t div_step(input div_lane_t x);
		logic [CHAN_W:0] t;
		logic            ge;
		div_lane_t       y;
		t = {x.rem, x.acc[QUO_W-1]};
		ge = (t >= {1'b0, x.den});
		y.den = x.den;
		y.rem = ge ? CHAN_W'(t - {1'b0, x.den}) : t[CHAN_W-1:0];
		y.acc = {x.acc[QUO_W-2:0], ge};
		return y;
	endfunction

endpackage

// ===== design/rhsv_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSV front end
// Finds max, min and difference, picks the hue case, forms the divide
// operands and the value field over two pipeline stages.
// ----------------------------------------------------------------------------
module rhsv_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                src_valid,
	output logic                src_take,
	input  rhsv_pkg::pixel_t    src,
	output logic                dst_valid,
	input  logic                dst_take,
	output rhsv_pkg::div_item_t dst
);

	logic [rhsv_pkg::CHAN_W-1:0] hi, lo, diff, mag;
	logic [rhsv_pkg::CHAN_W:0]   d;
	rhsv_pkg::hue_sel_t          sel;

	logic                        valid_s1, valid_s2;
	logic                        take_s1, take_s2;
	logic [rhsv_pkg::CHAN_W-1:0] hi_s1, diff_s1, mag_s1;
	logic                        neg_s1;
	rhsv_pkg::hue_sel_t          sel_s1;
	rhsv_pkg::div_item_t         item_s2;

	logic [19:0]                      hue_num;
	logic [rhsv_pkg::NUM_W-1:0]       hue_num_w, sat_num;
	logic [rhsv_pkg::VAL_PROD_W-1:0]  val_prod;

	always_comb begin
		hi = src.red;
		if (src.green > hi) hi = src.green;
		if (src.blue > hi) hi = src.blue;
		lo = src.red;
		if (src.green < lo) lo = src.green;
		if (src.blue < lo) lo = src.blue;
		diff = hi - lo;

		if (diff == '0) begin
			sel = rhsv_pkg::HUE_GRAY;
			d = '0;
		end else if (hi == src.red) begin
			sel = rhsv_pkg::HUE_RED;
			d = {1'b0, src.green} - {1'b0, src.blue};
		end else if (hi == src.green) begin
			sel = rhsv_pkg::HUE_GREEN;
			d = {1'b0, src.blue} - {1'b0, src.red};
		end else begin
			sel = rhsv_pkg::HUE_BLUE;
			d = {1'b0, src.red} - {1'b0, src.green};
		end
		mag = d[rhsv_pkg::CHAN_W] ? rhsv_pkg::CHAN_W'(-d) : d[rhsv_pkg::CHAN_W-1:0];
	end

	assign take_s2  = !valid_s2 || dst_take;
	assign take_s1  = !valid_s1 || take_s2;
	assign src_take = take_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take_s1) valid_s1 <= src_valid;
			if (take_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1 && src_valid) begin
			hi_s1   <= hi;
			diff_s1 <= diff;
			mag_s1  <= mag;
			neg_s1  <= d[rhsv_pkg::CHAN_W];
			sel_s1  <= sel;
		end
	end

	assign hue_num   = 20'(mag_s1) * 20'(rhsv_pkg::HUE_UNIT);
	assign hue_num_w = rhsv_pkg::NUM_W'(hue_num);
	assign sat_num   = rhsv_pkg::NUM_W'(diff_s1) * rhsv_pkg::NUM_W'(rhsv_pkg::PCT_SCALE);
	assign val_prod  = rhsv_pkg::VAL_PROD_W'(hi_s1) * rhsv_pkg::VAL_PROD_W'(rhsv_pkg::VAL_MUL);

	always_ff @(posedge clk) begin
		if (take_s2 && valid_s1) begin
			item_s2.hue.rem    <= hue_num_w[rhsv_pkg::NUM_W-1:rhsv_pkg::QUO_W];
			item_s2.hue.acc    <= hue_num_w[rhsv_pkg::QUO_W-1:0];
			item_s2.hue.den    <= diff_s1;
			item_s2.sat.rem    <= sat_num[rhsv_pkg::NUM_W-1:rhsv_pkg::QUO_W];
			item_s2.sat.acc    <= sat_num[rhsv_pkg::QUO_W-1:0];
			item_s2.sat.den    <= hi_s1;
			item_s2.side.sel   <= sel_s1;
			item_s2.side.neg   <= neg_s1;
			item_s2.side.black <= (hi_s1 == '0);
			item_s2.side.value <= val_prod[rhsv_pkg::VAL_SHIFT +: rhsv_pkg::FIELD_W];
		end
	end

	assign dst_valid = valid_s2;
	assign dst       = item_s2;

endmodule

// ===== design/rhsv_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSV divide pipeline
// Two restoring dividers in lockstep, three quotient bits per stage, with
// the hue case and value carried alongside.
// ----------------------------------------------------------------------------
module rhsv_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                src_valid,
	output logic                src_take,
	input  rhsv_pkg::div_item_t src,
	output logic                dst_valid,
	input  logic                dst_take,
	output rhsv_pkg::div_item_t dst
);

	localparam int N = rhsv_pkg::DIV_STAGES;

	rhsv_pkg::div_item_t item_s  [N];
	logic                valid_s [N];
	logic                take    [N];
	rhsv_pkg::div_item_t feed    [N+1];
	logic                feed_v  [N+1];

	assign feed[0]   = src;
	assign feed_v[0] = src_valid;

	for (genvar k = 0; k < N; k++) begin : g_stage
		rhsv_pkg::div_item_t nxt;

		if (k == N - 1) begin : g_last
			assign take[k] = !valid_s[k] || dst_take;
		end else begin : g_mid
			assign take[k] = !valid_s[k] || take[k+1];
		end

		always_comb begin
			nxt = feed[k];
			for (int j = 0; j < rhsv_pkg::DIV_STEPS; j++) begin
				nxt.hue = rhsv_pkg::div_step(nxt.hue);
				nxt.sat = rhsv_pkg::div_step(nxt.sat);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (take[k]) begin
				valid_s[k] <= feed_v[k];
			end
		end

		always_ff @(posedge clk) begin
			if (take[k] && feed_v[k]) begin
				item_s[k] <= nxt;
			end
		end

		assign feed[k+1]   = item_s[k];
		assign feed_v[k+1] = valid_s[k];
	end

	assign src_take  = take[0];
	assign dst_valid = feed_v[N];
	assign dst       = feed[N];

endmodule

// ===== design/rhsv_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSV back end
// Applies the hue offset and wrap, clears saturation for black, and holds
// the result in the output register.
// ----------------------------------------------------------------------------
module rhsv_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                src_valid,
	output logic                src_take,
	input  rhsv_pkg::div_item_t src,
	output logic                dst_valid,
	input  logic                dst_take,
	output rhsv_pkg::hsv_t      dst
);

	logic [rhsv_pkg::FIELD_W-1:0] q;
	rhsv_pkg::hsv_t               res;
	logic                         valid_s1;
	rhsv_pkg::hsv_t               hsv_s1;

	assign q = src.hue.acc;

	always_comb begin
		case (src.side.sel)
			rhsv_pkg::HUE_GRAY:  res.hue = '0;
			rhsv_pkg::HUE_RED:   res.hue = (src.side.neg && q != '0) ?
				rhsv_pkg::HUE_FULL - q : q;
			rhsv_pkg::HUE_GREEN: res.hue = src.side.neg ?
				rhsv_pkg::HUE_GREEN_OFS - q : rhsv_pkg::HUE_GREEN_OFS + q;
			rhsv_pkg::HUE_BLUE:  res.hue = src.side.neg ?
				rhsv_pkg::HUE_BLUE_OFS - q : rhsv_pkg::HUE_BLUE_OFS + q;
			default:             res.hue = '0;
		endcase
		res.saturation = src.side.black ? '0 : src.sat.acc;
		res.value      = src.side.value;
	end

	assign src_take = !valid_s1 || dst_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src_take) begin
			valid_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src_take && src_valid) begin
			hsv_s1 <= res;
		end
	end

	assign dst_valid = valid_s1;
	assign dst       = hsv_s1;

endmodule

// ===== design/rgb_to_hsv_converter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSV converter core
// Converts 8-bit RGB pixels to fixed-point hue, saturation and value.
// ----------------------------------------------------------------------------
// Input request: pixel (red, green, blue) with pixel_valid; pixel_stall
// holds it off. Output request: hsv (hue in degrees x64, saturation and
// value in percent x256) with hsv_valid; the receiver drives hsv_stall.
// From acceptance to hsv_valid: two front stages for max/min and operand
// setup, five divide stages of three quotient bits each, one output
// register. One pixel per clock while hsv_stall is low; the two 15-bit
// restoring dividers step in lockstep, one stage per three bits.
// Reset empties every stage; nothing is lost or reordered afterwards.
// While hsv_stall is high the output holds and the stages behind it keep
// filling bubbles; pixel_stall rises only once all stages hold a request.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pixel_valid,
	output logic             pixel_stall,
	input  rhsv_pkg::pixel_t pixel,
	output logic             hsv_valid,
	input  logic             hsv_stall,
	output rhsv_pkg::hsv_t   hsv
);

	logic                front_take, div_take, back_take;
	logic                front_valid, div_valid;
	rhsv_pkg::div_item_t front_item, div_item;

	rhsv_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (pixel_valid),
		.src_take  (front_take),
		.src       (pixel),
		.dst_valid (front_valid),
		.dst_take  (div_take),
		.dst       (front_item)
	);

	rhsv_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (front_valid),
		.src_take  (div_take),
		.src       (front_item),
		.dst_valid (div_valid),
		.dst_take  (back_take),
		.dst       (div_item)
	);

	rhsv_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (div_valid),
		.src_take  (back_take),
		.src       (div_item),
		.dst_valid (hsv_valid),
		.dst_take  (!hsv_stall),
		.dst       (hsv)
	);

	assign pixel_stall = !front_take;

`ifndef ASSERT_OFF
	a_full_only_when_out_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_stall |-> (hsv_valid && hsv_stall))
		else $error("input stalled while output stage can drain");

	a_field_range: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid |-> (hsv.hue <= rhsv_pkg::HUE_LIMIT &&
			hsv.saturation <= rhsv_pkg::PCT_LIMIT && hsv.value <= rhsv_pkg::PCT_LIMIT))
		else $error("result field out of range");

	a_black_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		(hsv_valid && hsv.value == '0) |-> (hsv.saturation == '0 && hsv.hue == '0))
		else $error("black pixel with nonzero hue or saturation");
`endif

endmodule
